// File: rtl/rvalu_pkg.sv
package rvalu_pkg;

  // data and register file geometry
  localparam int unsigned XLEN      = 32;
  localparam int unsigned REG_COUNT = 32;
  localparam int unsigned REG_AW    = $clog2(REG_COUNT);

  // operation codes carried by the input word
  typedef enum logic [1:0] {
    OP_EXEC = 2'd0,
    OP_LOAD = 2'd1,
    OP_READ = 2'd2,
    OP_NONE = 2'd3
  } op_e;

  // funct3 codes of the register-register group
  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;

  // funct7 codes
  localparam logic [6:0] F7_BASE = 7'd0;
  localparam logic [6:0] F7_ALT  = 7'd32;

  // commands from controller to datapath
  typedef struct packed {
    logic capture;  // latch the input word and issue register reads
    logic commit;   // compute, write back and load the result register
  } ctrl_cmd_t;

  // status from controller side
  typedef struct packed {
    logic out_free;  // result register empty or being emptied
  } ctrl_sts_t;

endpackage

// File: rtl/rvalu_ram.sv
module rvalu_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // one write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // two registered read ports, held while re_i is low
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule

// File: rtl/rvalu_ctrl.sv
module rvalu_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output rvalu_pkg::ctrl_cmd_t cmd_o,
  output rvalu_pkg::ctrl_sts_t sts_o
);
  import rvalu_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic accept;
  logic out_free;

  assign accept   = in_valid_i && (state_q == ST_IDLE);
  assign out_free = !out_valid_q || out_ready_i;

  // sequencer: idle -> exec (wait for free result register) -> idle
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // result register occupancy
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (state_q == ST_EXEC && out_free) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o     = (state_q == ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign cmd_o.capture  = accept;
  assign cmd_o.commit   = (state_q == ST_EXEC) && out_free;
  assign sts_o.out_free = out_free;

endmodule

// File: rtl/rvalu_dpath.sv
module rvalu_dpath (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  rvalu_pkg::ctrl_cmd_t               cmd_i,
  input  logic [1:0]                         operation_i,
  input  logic [rvalu_pkg::XLEN-1:0]         instruction_i,
  input  logic [rvalu_pkg::REG_AW-1:0]       reg_index_i,
  input  logic [rvalu_pkg::XLEN-1:0]         load_value_i,
  output logic [rvalu_pkg::REG_AW-1:0]       dest_index_o,
  output logic [rvalu_pkg::XLEN-1:0]         result_value_o,
  output logic                               wrote_o,
  output logic                               illegal_o
);
  import rvalu_pkg::*;

  // latched word
  op_e               op_q;
  logic [XLEN-1:0]   instr_q;
  logic [REG_AW-1:0] ridx_q;
  logic [XLEN-1:0]   lval_q;

  // register file valid bits, cleared at reset
  logic [REG_COUNT-1:0] valid_q;
  logic                 a_vld_q, b_vld_q;

  // read addresses and data
  logic [REG_AW-1:0] raddr_a, raddr_b;
  logic [XLEN-1:0]   ram_a, ram_b;
  logic [XLEN-1:0]   a, b;

  // decode
  logic [REG_AW-1:0] rd;
  logic [2:0]        f3;
  logic [6:0]        f7;
  logic [4:0]        sh;

  // results
  logic [XLEN-1:0]   alu;
  logic              alu_ok;
  logic [REG_AW-1:0] dest;
  logic [XLEN-1:0]   value;
  logic              do_write;
  logic              illegal;

  // register reads use rs1/rs2 for execute, reg_index otherwise
  always_comb begin
    if (op_e'(operation_i) == OP_EXEC) begin
      raddr_a = instruction_i[19:15];
      raddr_b = instruction_i[24:20];
    end else begin
      raddr_a = reg_index_i;
      raddr_b = reg_index_i;
    end
  end

  // latch the input word
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q    <= op_e'(operation_i);
      instr_q <= instruction_i;
      ridx_q  <= reg_index_i;
      lval_q  <= load_value_i;
      a_vld_q <= valid_q[raddr_a];
      b_vld_q <= valid_q[raddr_b];
    end
  end

  rvalu_ram #(
    .WIDTH (XLEN),
    .DEPTH (REG_COUNT)
  ) u_regfile (
    .clk_i     (clk_i),
    .we_i      (do_write),
    .waddr_i   (dest),
    .wdata_i   (value),
    .re_i      (cmd_i.capture),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (ram_a),
    .rdata_b_o (ram_b)
  );

  // never-written entries read as zero, x0 is never written
  assign a = a_vld_q ? ram_a : '0;
  assign b = b_vld_q ? ram_b : '0;

  assign rd = instr_q[11:7];
  assign f3 = instr_q[14:12];
  assign f7 = instr_q[31:25];
  assign sh = b[4:0];

  // alu
  always_comb begin
    alu    = '0;
    alu_ok = 1'b1;
    unique case (f3)
      F3_ADD: begin
        if (f7 == F7_BASE)     alu = a + b;
        else if (f7 == F7_ALT) alu = a - b;
        else                   alu_ok = 1'b0;
      end
      F3_SLL:  alu = a << sh;
      F3_SLT:  alu = {{(XLEN-1){1'b0}}, ($signed(a) < $signed(b))};
      F3_SLTU: alu = {{(XLEN-1){1'b0}}, (a < b)};
      F3_XOR:  alu = a ^ b;
      F3_SR:   alu = (f7 == F7_BASE) ? (a >> sh) : XLEN'($signed(a) >>> sh);
      F3_OR:   alu = a | b;
      F3_AND:  alu = a & b;
      default: alu = '0;
    endcase
  end

  // result selection and write enable
  always_comb begin
    dest    = '0;
    value   = '0;
    illegal = 1'b0;
    unique case (op_q)
      OP_EXEC: begin
        dest    = rd;
        value   = alu_ok ? alu : '0;
        illegal = !alu_ok;
      end
      OP_LOAD: begin
        dest  = ridx_q;
        value = lval_q;
      end
      OP_READ: begin
        dest  = ridx_q;
        value = a;
      end
      default: begin
        dest  = '0;
        value = '0;
      end
    endcase
    do_write = cmd_i.commit && (dest != '0) &&
               ((op_q == OP_EXEC && alu_ok) || op_q == OP_LOAD);
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (do_write) begin
      valid_q[dest] <= 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      dest_index_o   <= dest;
      result_value_o <= value;
      wrote_o        <= do_write;
      illegal_o      <= illegal;
    end
  end

endmodule

// File: rtl/rv32i_register_alu_execute.sv
// channel | valid      | ready       | word fields
// input   | in_valid_i | in_ready_o  | operation_i instruction_i reg_index_i load_value_i
// output  | out_valid_o| out_ready_i | dest_index_o result_value_o wrote_o illegal_o
//
// each word is first latched while the register file is read
// (registered read ports), then computed and written back into the result register.
// a new word is accepted only after the previous word has moved into the result register.
// rst_ni clears the controller and the register file valid bits; all registers read zero.
// a stalled output holds the word in execute until the result register frees.
module rv32i_register_alu_execute (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   operation_i,
  input  logic [rvalu_pkg::XLEN-1:0]   instruction_i,
  input  logic [rvalu_pkg::REG_AW-1:0] reg_index_i,
  input  logic [rvalu_pkg::XLEN-1:0]   load_value_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [rvalu_pkg::REG_AW-1:0] dest_index_o,
  output logic [rvalu_pkg::XLEN-1:0]   result_value_o,
  output logic                         wrote_o,
  output logic                         illegal_o
);
  import rvalu_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  // sequencer
  rvalu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_o       (sts)
  );

  // register file and alu
  rvalu_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .operation_i    (operation_i),
    .instruction_i  (instruction_i),
    .reg_index_i    (reg_index_i),
    .load_value_i   (load_value_i),
    .dest_index_o   (dest_index_o),
    .result_value_o (result_value_o),
    .wrote_o        (wrote_o),
    .illegal_o      (illegal_o)
  );

  // one word in flight: no accept right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("word accepted while previous word in execute");

  // commit only into a free result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |-> sts.out_free)
    else $error("commit into occupied result register");

  // x0 is never reported as written
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && wrote_o) |-> (dest_index_o != '0))
    else $error("write reported for x0");

  // illegal words write nothing and report zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && illegal_o) |-> (!wrote_o && result_value_o == '0))
    else $error("illegal word wrote or reported a value");

endmodule
